// ===== rtl/smf_pkg.sv =====
// ============================================================================
// smf_pkg
// Shared types and constants for the sliding-window median filter.
// ============================================================================
`default_nettype none

package smf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HW_W       = 2;
    localparam int WINDOW_CAP = 15;
    localparam int AGE_W      = $clog2(WINDOW_CAP + 1);
    localparam int LEN_W      = $clog2(WINDOW_CAP + 1) + 1;

    typedef struct packed {
        logic                       vld;
        logic [AGE_W-1:0]           age;
        logic signed [SAMPLE_W-1:0] val;
    } cell_t;

    typedef struct packed {
        logic dp;
        logic below;
    } link_t;

    localparam cell_t EMPTY_CELL = '{vld: 1'b0, age: '0, val: '0};

endpackage

`default_nettype wire

// ===== rtl/smf_cell.sv =====
// ============================================================================
// smf_cell
// One cell of the sorted window chain: holds one sample and its age.
// ============================================================================
`default_nettype none

module smf_cell (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  load,
    input  wire                                  flush,
    input  wire                                  restart,
    input  wire logic signed [smf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [smf_pkg::AGE_W-1:0]       last_age,
    input  wire smf_pkg::cell_t                  left,
    input  wire smf_pkg::cell_t                  right,
    input  wire                                  le_right,
    input  wire smf_pkg::link_t                  link_left,
    output smf_pkg::cell_t                       cur,
    output logic                                 le,
    output smf_pkg::link_t                       link,
    output smf_pkg::cell_t                       nxt,
    output logic                                 held
);

    smf_pkg::cell_t cell_reg;
    smf_pkg::cell_t cell_next;
    smf_pkg::cell_t e_here;
    smf_pkg::cell_t e_left;
    logic           del;

    always_comb
    begin
        cur     = cell_reg;
        cur.vld = cell_reg.vld & ~restart;
        del     = cur.vld && (cur.age == last_age);
        le      = cur.vld && !del && ($signed(cur.val) <= $signed(sample));
        link.dp    = del | link_left.dp;
        link.below = link.dp ? le_right : le;

        e_here     = link.dp ? right : cur;
        e_here.age = smf_pkg::AGE_W'(e_here.age + 1'b1);
        e_left     = link_left.dp ? cur : left;
        e_left.age = smf_pkg::AGE_W'(e_left.age + 1'b1);

        if (link.below)
        begin
            cell_next = e_here;
        end
        else if (link_left.below)
        begin
            cell_next.vld = 1'b1;
            cell_next.age = '0;
            cell_next.val = sample;
        end
        else
        begin
            cell_next = e_left;
        end
        nxt  = cell_next;
        held = cell_reg.vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= smf_pkg::EMPTY_CELL;
        end
        else if (flush)
        begin
            cell_reg.vld <= 1'b0;
        end
        else if (load)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_filter_unit.sv =====
// ============================================================================
// sliding_window_median_filter_unit
// Running median over the last 3, 5 or 7 signed 16-bit samples.
// ============================================================================
// Usage:
//   Input channel: smp_valid / smp_stall carry one word of restart and
//   sample. Output channel: med_valid / med_stall carry the median.
//   A word moves at a rising edge with valid high and stall low.
//   The median is registered: the median of a sample accepted at one
//   edge is offered from the next cycle. One sample per cycle is sustained
//   while med_stall is low; the figure is set by the chain of sorted cells,
//   which drops the oldest sample and inserts the new one in one update,
//   with the median read from the cell at half the fill count.
//   While med_valid is high and med_stall is high, smp_stall is high and
//   the pending median holds.
//   half_window_we writes the window length (2*half_window+1, zero reads as
//   one) and empties the window; write it only while idle.
//   Reset empties the window, sets half_window to 1 and drops med_valid.
//   restart empties the window before its sample is stored.
// ============================================================================
`default_nettype none

module sliding_window_median_filter_unit #(
    parameter int MAX_WINDOW = 7
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       half_window_we,
    input  wire logic [smf_pkg::HW_W-1:0]             half_window_wdata,
    input  wire                                       smp_valid,
    output logic                                      smp_stall,
    input  wire                                       restart,
    input  wire logic signed [smf_pkg::SAMPLE_W-1:0]  sample,
    output logic                                      med_valid,
    input  wire                                       med_stall,
    output logic signed [smf_pkg::SAMPLE_W-1:0]       median
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);

    logic [smf_pkg::HW_W-1:0]            hw_reg;
    logic [CNT_W-1:0]                    fill_reg;
    logic [CNT_W-1:0]                    fill_next;
    logic                                med_valid_reg;
    logic                                med_valid_next;
    logic signed [smf_pkg::SAMPLE_W-1:0] median_reg;
    logic signed [smf_pkg::SAMPLE_W-1:0] median_next;

    logic [smf_pkg::HW_W-1:0]  hw_eff;
    logic [smf_pkg::LEN_W-1:0] len_wide;
    logic [CNT_W-1:0]          win_len;
    logic [smf_pkg::AGE_W-1:0] last_age;
    logic [IDX_W-1:0]          med_idx;
    logic                      accept;

    smf_pkg::cell_t cur_a   [MAX_WINDOW];
    smf_pkg::cell_t nxt_a   [MAX_WINDOW];
    smf_pkg::cell_t left_a  [MAX_WINDOW];
    smf_pkg::cell_t right_a [MAX_WINDOW];
    smf_pkg::link_t link_a  [MAX_WINDOW];
    smf_pkg::link_t lin_a   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] le_a;
    logic [MAX_WINDOW-1:0] le_in_a;
    logic [MAX_WINDOW-1:0] held_a;

    always_comb
    begin
        hw_eff   = (hw_reg == '0) ? smf_pkg::HW_W'(1) : hw_reg;
        len_wide = smf_pkg::LEN_W'({hw_eff, 1'b1});
        if (len_wide > smf_pkg::LEN_W'(MAX_WINDOW))
        begin
            len_wide = smf_pkg::LEN_W'(MAX_WINDOW);
        end
        if (!len_wide[0])
        begin
            len_wide = smf_pkg::LEN_W'(len_wide - 1'b1);
        end
        win_len  = CNT_W'(len_wide);
        last_age = smf_pkg::AGE_W'(len_wide - 1'b1);
    end

    assign smp_stall = med_valid_reg & med_stall;
    assign accept    = smp_valid & ~smp_stall;

    always_comb
    begin
        if (restart)
        begin
            fill_next = CNT_W'(1);
        end
        else if (fill_reg >= win_len)
        begin
            fill_next = win_len;
        end
        else
        begin
            fill_next = CNT_W'(fill_reg + 1'b1);
        end
        med_idx     = IDX_W'(fill_next >> 1);
        median_next = nxt_a[med_idx].val;

        if (accept)
        begin
            med_valid_next = 1'b1;
        end
        else
        begin
            med_valid_next = med_valid_reg & med_stall;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_chain
            if (i == 0)
            begin : g_first
                assign left_a[i] = smf_pkg::EMPTY_CELL;
                assign lin_a[i]  = '{dp: 1'b0, below: 1'b1};
            end
            else
            begin : g_mid
                assign left_a[i] = cur_a[i-1];
                assign lin_a[i]  = link_a[i-1];
            end
            if (i == MAX_WINDOW - 1)
            begin : g_last
                assign right_a[i] = smf_pkg::EMPTY_CELL;
                assign le_in_a[i] = 1'b0;
            end
            else
            begin : g_inner
                assign right_a[i] = cur_a[i+1];
                assign le_in_a[i] = le_a[i+1];
            end

            smf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (accept),
                .flush     (half_window_we),
                .restart   (restart),
                .sample    (sample),
                .last_age  (last_age),
                .left      (left_a[i]),
                .right     (right_a[i]),
                .le_right  (le_in_a[i]),
                .link_left (lin_a[i]),
                .cur       (cur_a[i]),
                .le        (le_a[i]),
                .link      (link_a[i]),
                .nxt       (nxt_a[i]),
                .held      (held_a[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= smf_pkg::HW_W'(1);
            fill_reg      <= '0;
            med_valid_reg <= 1'b0;
        end
        else
        begin
            med_valid_reg <= med_valid_next;
            if (half_window_we)
            begin
                hw_reg   <= half_window_wdata;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg <= median_next;
        end
    end

    assign med_valid = med_valid_reg;
    assign median    = median_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_len)
        else $error("fill count beyond window length");

    a_fill_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(held_a) == fill_reg)
        else $error("held cells disagree with fill count");

    a_cfg_empty: assert property (@(posedge clk) disable iff (!rst_n)
        half_window_we |=> (fill_reg == '0) && (held_a == '0))
        else $error("window not emptied by register write");

    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> med_valid)
        else $error("accepted sample gave no median");

endmodule

`default_nettype wire
